// File: rtl/fcg_pkg.sv
`timescale 1ns / 1ps
// Package for the four-corner gradient pixel block.
// Holds payload structs, register codes, reset values and fixed widths.
package fcg_pkg;

  localparam int POS_W        = 14;
  localparam int SIDE_W       = 15;
  localparam int Q_W          = 16;
  localparam int W_W          = Q_W + 1;
  localparam int CHANNEL_BITS = 16;
  localparam int MAX_SIDE     = 16384;
  localparam int DIV_STG      = 4;
  localparam int DIV_STEPS    = Q_W / DIV_STG;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  localparam logic [W_W-1:0] W_ONE    = W_W'(1 << Q_W);
  localparam logic [15:0]    CHAN_MAX = 16'((1 << CHANNEL_BITS) - 1);

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR     = 3'd6;

  localparam logic [SIDE_W-1:0] RST_SIDE      = 15'd1024;
  localparam logic [63:0]       RST_CORNER_TL = 64'hFFFF_0000_0000_FFFF;
  localparam logic [63:0]       RST_CORNER_TR = 64'h0000_FFFF_0000_FFFF;
  localparam logic [63:0]       RST_CORNER_BL = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0]       RST_CORNER_BR = 64'hFFFF_FFFF_0000_FFFF;

  typedef struct packed {
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;
  } fcg_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } fcg_out_t;

  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] q;
  } fcg_norm_t;

endpackage

// File: rtl/four_corner_gradient_pixel_top.sv
`timescale 1ns / 1ps
// Top level of the four-corner gradient pixel block: config registers and pipeline.
// Depends on fcg_pkg and fcg_norm.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data   (fcg_in_t)
//  out     | output    | out_valid / out_ready| out_data  (fcg_out_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One pixel per cycle while the output is not stalled; the pipeline has four divider
// stages (four quotient bits each), three weight stages (square, cube, smoothstep),
// two blend multiply stages and the rounding output register.
// Reset is synchronous, active low, clears valid bits and loads the config
// registers with their reset values.
// The whole pipeline holds when the output register is full and not taken.
module four_corner_gradient_pixel_top import fcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fcg_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NSTG  = 10;
  localparam int S_C1  = DIV_STG;
  localparam int S_C3  = DIV_STG + 2;
  localparam int S_B1  = DIV_STG + 3;

  logic              blend_mode_r;
  logic [SIDE_W-1:0] canvas_width_r;
  logic [SIDE_W-1:0] canvas_height_r;
  logic [63:0]       corner_r [4];

  logic [NSTG-1:0]   vld_r;
  logic              adv;

  logic [SIDE_W-1:0] side_w;
  logic [SIDE_W-1:0] side_h;
  fcg_norm_t         nrm [2];

  logic              sat_c1_r [2];
  logic [Q_W-1:0]    q_c1_r   [2];
  logic [31:0]       t2_c1_r  [2];
  logic              sat_c2_r [2];
  logic [Q_W-1:0]    q_c2_r   [2];
  logic [31:0]       t2_c2_r  [2];
  logic [47:0]       t3_c2_r  [2];
  logic [W_W-1:0]    w_r      [2];
  logic [W_W-1:0]    wv_b1_r;

  logic signed [34:0] top_r [4];
  logic signed [34:0] bot_r [4];
  logic signed [53:0] mix_r [4];
  fcg_out_t           out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r    <= 1'b1;
      canvas_width_r  <= RST_SIDE;
      canvas_height_r <= RST_SIDE;
      corner_r[0]     <= RST_CORNER_TL;
      corner_r[1]     <= RST_CORNER_TR;
      corner_r[2]     <= RST_CORNER_BL;
      corner_r[3]     <= RST_CORNER_BR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_MODE:    blend_mode_r    <= cfg_wdata[0];
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata[SIDE_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata[SIDE_W-1:0];
        REG_CORNER_TL:     corner_r[0]     <= cfg_wdata;
        REG_CORNER_TR:     corner_r[1]     <= cfg_wdata;
        REG_CORNER_BL:     corner_r[2]     <= cfg_wdata;
        REG_CORNER_BR:     corner_r[3]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    if (s == '0) begin
      return SIDE_W'(1);
    end else if ({2'b0, s} > 17'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end
    return s;
  endfunction

  assign side_w = clamp_side(canvas_width_r);
  assign side_h = clamp_side(canvas_height_r);

  // pipeline control
  assign adv      = !vld_r[NSTG-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  fcg_norm u_norm_col (
    .clk  (clk),
    .en   (adv),
    .pos  (in_data.col_pos),
    .side (side_w),
    .res  (nrm[0])
  );

  fcg_norm u_norm_row (
    .clk  (clk),
    .en   (adv),
    .pos  (in_data.row_pos),
    .side (side_h),
    .res  (nrm[1])
  );

  // weight stages
  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [49:0] s48;
    logic [17:0] s16;
    logic [W_W-1:0] w_lin;
    logic [W_W-1:0] w_cub;

    assign s48   = ({t2_c2_r[a], 17'b0} + {1'b0, t2_c2_r[a], 16'b0})
                   - {1'b0, t3_c2_r[a], 1'b0};
    assign s16   = 18'((s48 + 50'h8000_0000) >> 32);
    assign w_lin = sat_c2_r[a] ? W_ONE : {1'b0, q_c2_r[a]};
    assign w_cub = (sat_c2_r[a] || s16 > {1'b0, W_ONE}) ? W_ONE : s16[W_W-1:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        sat_c1_r[a] <= nrm[a].sat;
        q_c1_r[a]   <= nrm[a].q;
        t2_c1_r[a]  <= nrm[a].q * nrm[a].q;
        sat_c2_r[a] <= sat_c1_r[a];
        q_c2_r[a]   <= q_c1_r[a];
        t2_c2_r[a]  <= t2_c1_r[a];
        t3_c2_r[a]  <= t2_c1_r[a] * {32'b0, q_c1_r[a]};
        w_r[a]      <= blend_mode_r ? w_cub : w_lin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wv_b1_r <= w_r[1];
    end
  end

  // blend stages, one lane per channel
  for (genvar k = 0; k < 4; k++) begin : g_chan
    localparam int SH = 48 - 16 * k;
    logic [15:0]        ca, cb, cc, cd;
    logic signed [16:0] dtop, dbot;
    logic signed [34:0] top_nxt, bot_nxt;
    logic signed [35:0] dv;
    logic signed [53:0] mix_nxt;
    logic signed [53:0] radd;
    logic [21:0]        rnd;
    logic [15:0]        o;

    assign ca   = corner_r[0][SH +: 16] & CHAN_MAX;
    assign cb   = corner_r[1][SH +: 16] & CHAN_MAX;
    assign cc   = corner_r[2][SH +: 16] & CHAN_MAX;
    assign cd   = corner_r[3][SH +: 16] & CHAN_MAX;
    assign dtop = $signed({1'b0, cb}) - $signed({1'b0, ca});
    assign dbot = $signed({1'b0, cd}) - $signed({1'b0, cc});
    assign top_nxt = $signed({3'b0, ca, 16'b0}) + $signed({1'b0, w_r[0]}) * dtop;
    assign bot_nxt = $signed({3'b0, cc, 16'b0}) + $signed({1'b0, w_r[0]}) * dbot;

    assign dv      = $signed({bot_r[k][34], bot_r[k]}) - $signed({top_r[k][34], top_r[k]});
    assign mix_nxt = $signed({{3{top_r[k][34]}}, top_r[k], 16'b0})
                     + $signed({1'b0, wv_b1_r}) * dv;

    assign radd = mix_r[k] + 54'sh8000_0000;
    assign rnd  = radd[53:32];
    always_comb begin
      if (mix_r[k][53]) begin
        o = '0;
      end else if (rnd > {6'b0, CHAN_MAX}) begin
        o = CHAN_MAX;
      end else begin
        o = rnd[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        top_r[k] <= top_nxt;
        bot_r[k] <= bot_nxt;
        mix_r[k] <= mix_nxt;
      end
    end

    if (k == 0) begin : g_r
      always_ff @(posedge clk) if (adv) out_r.red_out <= o;
    end else if (k == 1) begin : g_g
      always_ff @(posedge clk) if (adv) out_r.green_out <= o;
    end else if (k == 2) begin : g_b
      always_ff @(posedge clk) if (adv) out_r.blue_out <= o;
    end else begin : g_a
      always_ff @(posedge clk) if (adv) out_r.alpha_out <= o;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[S_C1-1]) |=> vld_r[S_C1])
    else $error("divider stage valid lost");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_C3] |-> (w_r[0] <= W_ONE && w_r[1] <= W_ONE))
    else $error("blend weight above one");

  a_edge_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_B1] |-> (!top_r[0][34] && !bot_r[0][34] && !top_r[3][34] && !bot_r[3][34]))
    else $error("edge blend went negative");
`endif

endmodule

// File: rtl/fcg_norm.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: position / side as a Q16 fraction, saturating at one.
// Depends on fcg_pkg.
module fcg_norm import fcg_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [POS_W-1:0]  pos,
  input  logic [SIDE_W-1:0] side,
  output fcg_norm_t         res
);

  logic [SIDE_W-1:0] rem_r [DIV_STG];
  logic [Q_W-1:0]    q_r   [DIV_STG];
  logic              sat_r [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    logic [SIDE_W-1:0] rem_src;
    logic [Q_W-1:0]    q_src;
    logic              sat_src;
    logic [SIDE_W-1:0] rem_nxt;
    logic [Q_W-1:0]    q_nxt;
    logic [SIDE_W:0]   r2;

    if (k == 0) begin : g_first
      assign rem_src = {1'b0, pos};
      assign q_src   = '0;
      assign sat_src = ({1'b0, pos} >= side);
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign q_src   = q_r[k-1];
      assign sat_src = sat_r[k-1];
    end

    always_comb begin
      rem_nxt = rem_src;
      q_nxt   = q_src;
      r2      = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        r2 = {rem_nxt, 1'b0};
        if (r2 >= {1'b0, side}) begin
          rem_nxt = SIDE_W'(r2 - {1'b0, side});
          q_nxt   = {q_nxt[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = r2[SIDE_W-1:0];
          q_nxt   = {q_nxt[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        sat_r[k] <= sat_src;
      end
    end
  end

  assign res.sat = sat_r[DIV_STG-1];
  assign res.q   = q_r[DIV_STG-1];

endmodule
